/* sv/assert_macros.svh */
// Assertion helpers used by the top-level RTL file; they expect clk and rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define AHVL_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define AHVL_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

/* sv/ahvl_pkg.sv */
// ----------------------------------------------------------------------------
// ahvl_pkg
// Shared constants, types and helper functions of the altitude hold block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package ahvl_pkg;

  localparam int CORDIC_STEPS_DEF = 16;
  localparam int TABLE_LEN        = 24;
  localparam int CW               = 34;   // rotator datapath width

  localparam logic [29:0] GAIN_Q30 = 30'd652032874;
  localparam logic signed [35:0] OUT_LIM36 = 36'sd8000;
  localparam logic [15:0] AGE_LIMIT = 16'd500;
  localparam logic [17:0] AIR_ERR   = 18'd150;

  localparam logic [2:0] CFG_TARGET    = 3'd0;
  localparam logic [2:0] CFG_GAIN      = 3'd1;
  localparam logic [2:0] CFG_MAX_CLIMB = 3'd2;
  localparam logic [2:0] CFG_MAX_GND   = 3'd3;
  localparam logic [2:0] CFG_MAX_TURN  = 3'd4;

  typedef struct packed {
    logic start;
  } unit_ctl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } unit_sts_t;

  // arctangent table, 2^32 units per turn
  function automatic logic [29:0] atan_val(input logic [4:0] i);
    logic [29:0] v;
    case (i)
      5'd0:  v = 30'd536870912;
      5'd1:  v = 30'd316933406;
      5'd2:  v = 30'd167458907;
      5'd3:  v = 30'd85004756;
      5'd4:  v = 30'd42667331;
      5'd5:  v = 30'd21354465;
      5'd6:  v = 30'd10680862;
      5'd7:  v = 30'd5340245;
      5'd8:  v = 30'd2670675;
      5'd9:  v = 30'd1335087;
      5'd10: v = 30'd667544;
      5'd11: v = 30'd333772;
      5'd12: v = 30'd166886;
      5'd13: v = 30'd83443;
      5'd14: v = 30'd41722;
      5'd15: v = 30'd20861;
      5'd16: v = 30'd10430;
      5'd17: v = 30'd5215;
      5'd18: v = 30'd2608;
      5'd19: v = 30'd1304;
      5'd20: v = 30'd652;
      5'd21: v = 30'd326;
      5'd22: v = 30'd163;
      5'd23: v = 30'd81;
      default: v = 30'd0;
    endcase
    return v;
  endfunction

  // clamp to +-lim, then to the output range
  function automatic logic [13:0] sat14(input logic signed [35:0] v, input logic [12:0] lim);
    logic signed [35:0] l;
    logic signed [35:0] r;
    l = $signed({23'd0, lim});
    r = v;
    if (r > l) r = l;
    else if (r < -l) r = -l;
    if (r > OUT_LIM36) r = OUT_LIM36;
    else if (r < -OUT_LIM36) r = -OUT_LIM36;
    return r[13:0];
  endfunction

endpackage

`default_nettype wire

/* sv/ahvl_cordic.sv */
// ----------------------------------------------------------------------------
// ahvl_cordic
// Iterative vector rotator: one micro-rotation per cycle on shared adders.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ahvl_cordic import ahvl_pkg::*; #(
  parameter int STEPS = CORDIC_STEPS_DEF
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire unit_ctl_t            ctl,
  input  wire logic signed [CW-1:0] x0,
  input  wire logic signed [CW-1:0] y0,
  input  wire logic signed [CW-1:0] z0,
  output unit_sts_t                 sts,
  output logic signed [CW-1:0]      x,
  output logic signed [CW-1:0]      y
);

  localparam int CNT_W = $clog2(STEPS);

  logic signed [CW-1:0] x_r, y_r, z_r;
  logic [CNT_W-1:0]     cnt_r;
  logic                 busy_r, done_r;
  logic signed [CW-1:0] dx, dy, at;

  assign dx = y_r >>> cnt_r;
  assign dy = x_r >>> cnt_r;
  assign at = $signed({{(CW-30){1'b0}}, atan_val(5'(cnt_r))});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (ctl.start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        if (cnt_r == CNT_W'(STEPS - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
        cnt_r <= cnt_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.start) begin
      x_r <= x0;
      y_r <= y0;
      z_r <= z0;
    end else if (busy_r) begin
      if (!z_r[CW-1]) begin
        x_r <= x_r - dx;
        y_r <= y_r + dy;
        z_r <= z_r - at;
      end else begin
        x_r <= x_r + dx;
        y_r <= y_r - dy;
        z_r <= z_r + at;
      end
    end
  end

  assign sts.busy = busy_r;
  assign sts.done = done_r;
  assign x = x_r;
  assign y = y_r;

endmodule

`default_nettype wire

/* sv/ahvl_isqrt.sv */
// ----------------------------------------------------------------------------
// ahvl_isqrt
// Integer square root, two radicand bits per cycle, with remainder flag.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ahvl_isqrt import ahvl_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire unit_ctl_t   ctl,
  input  wire logic [63:0] n,
  output unit_sts_t        sts,
  output logic [31:0]      root,
  output logic             rem_nz
);

  logic [63:0] n_r, res_r, bit_r, trial;
  logic        busy_r, done_r;

  assign trial = res_r + bit_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (ctl.start) begin
        busy_r <= 1'b1;
      end else if (busy_r && bit_r[0]) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.start) begin
      n_r   <= n;
      res_r <= '0;
      bit_r <= 64'd1 << 62;
    end else if (busy_r) begin
      if (n_r >= trial) begin
        n_r   <= n_r - trial;
        res_r <= (res_r >> 1) + bit_r;
      end else begin
        res_r <= res_r >> 1;
      end
      bit_r <= bit_r >> 2;
    end
  end

  assign sts.busy = busy_r;
  assign sts.done = done_r;
  assign root     = res_r[31:0];
  assign rem_nz   = (n_r != 64'd0);

endmodule

`default_nettype wire

/* sv/ahvl_div.sv */
// ----------------------------------------------------------------------------
// ahvl_div
// Restoring divider, one quotient bit per cycle, 14-bit quotient.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ahvl_div import ahvl_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire unit_ctl_t   ctl,
  input  wire logic [43:0] num,
  input  wire logic [31:0] den,
  output unit_sts_t        sts,
  output logic [13:0]      q
);

  logic [43:0] rem_r;
  logic [31:0] den_r;
  logic [13:0] q_r;
  logic [3:0]  k_r;
  logic        busy_r, done_r;
  logic [45:0] trial;
  logic        ge;

  assign trial = {14'd0, den_r} << k_r;
  assign ge    = ({2'b00, rem_r} >= trial);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      k_r    <= '0;
    end else begin
      done_r <= 1'b0;
      if (ctl.start) begin
        busy_r <= 1'b1;
        k_r    <= 4'd13;
      end else if (busy_r) begin
        if (k_r == 4'd0) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end else begin
          k_r <= k_r - 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.start) begin
      rem_r <= num;
      den_r <= den;
      q_r   <= '0;
    end else if (busy_r) begin
      if (ge) rem_r <= rem_r - trial[43:0];
      q_r <= {q_r[12:0], ge};
    end
  end

  assign sts.busy = busy_r;
  assign sts.done = done_r;
  assign q        = q_r;

endmodule

`default_nettype wire

/* sv/altitude_hold_velocity_limiter_top.sv */
// With the horizontal path off the vertical result goes straight to the output stage; with
// it on, the rotator, gain multiply, squares and square root run, then the divider too when
// the ground speed limits. Throughput: one item at a time, set by the rotator, the square
// root and the divider; a new item is taken only in the idle state, and a stalled result
// holds the block in its final state until the output register frees up.
// Reset (rst_n low, synchronous) restores register defaults and clears airborne.
// ----------------------------------------------------------------------------
// altitude_hold_velocity_limiter_top
// Altitude hold with vertical and horizontal velocity limiting.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module altitude_hold_velocity_limiter_top import ahvl_pkg::*; #(
  parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_we,
  input  wire logic [2:0]  cfg_idx,
  input  wire logic [14:0] cfg_wdata,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  // altitude_mm, heading_angle, cmd_fwd_speed, cmd_side_speed, cmd_turn_rate,
  // cmd_seen, cmd_age_ms
  input  wire logic [95:0] in_tdata,
  output logic             out_tvalid,
  input  wire logic        out_tready,
  // vel_east, vel_north, vel_up, turn_rate_out, airborne_out
  output logic [63:0]      out_tdata
);

  typedef enum logic [8:0] {
    S_IDLE = 9'b000000001,
    S_VERT = 9'b000000010,
    S_CORD = 9'b000000100,
    S_GMUL = 9'b000001000,
    S_SQ   = 9'b000010000,
    S_SQRT = 9'b000100000,
    S_DIVX = 9'b001000000,
    S_DIVY = 9'b010000000,
    S_FIN  = 9'b100000000
  } state_t;

  state_t state_r, state_nxt;

  logic [14:0] tgt_r;
  logic [11:0] gain_r;
  logic [12:0] mcs_r, mgs_r, mtr_r;

  logic signed [15:0] alt_r;
  logic [15:0]        head_r, age_r;
  logic signed [14:0] fwd_r, side_r, turn_r;
  logic               seen_r;

  logic               air_r;
  logic [13:0]        ve_r, vn_r, vz_r, vr_r;
  logic [1:0]         ph_r;
  logic signed [65:0] acc_r;
  logic signed [CW-1:0] cx_r, cy_r;
  logic signed [31:0] xq_r, yq_r;
  logic [63:0]        sum_r;
  logic [43:0]        dx_r, dy_r;
  logic               out_valid_r;
  logic [63:0]        out_data_r;

  // ---------------- vertical channel and enable
  logic signed [17:0] err;
  logic [17:0]        abs_err;
  logic signed [30:0] vprod;
  logic [30:0]        vmag;
  logic [22:0]        vq;
  logic signed [35:0] vz36;
  logic               air_new, en;

  assign err     = $signed({3'b000, tgt_r}) - $signed({{2{alt_r[15]}}, alt_r});
  assign abs_err = err[17] ? 18'(-err) : 18'(err);
  assign vprod   = err * $signed({1'b0, gain_r});
  assign vmag    = vprod[30] ? 31'(-vprod) : 31'(vprod);
  assign vq      = vmag[30:8];
  assign vz36    = vprod[30] ? -$signed({13'd0, vq}) : $signed({13'd0, vq});
  assign air_new = air_r | (abs_err < AIR_ERR);
  assign en      = air_new & seen_r & (age_r < AGE_LIMIT);

  // ---------------- heading reduction
  logic signed [16:0] s0, s1;
  logic               flip;
  logic signed [CW-1:0] fx, fy;

  assign s0   = $signed({head_r[15], head_r});
  assign flip = (s0 > 17'sd16384) || (s0 < -17'sd16384);
  assign s1   = (s0 > 17'sd16384) ? s0 - 17'sd32768 :
                (s0 < -17'sd16384) ? s0 + 17'sd32768 : s0;
  assign fx   = $signed({{(CW-15){fwd_r[14]}}, fwd_r});
  assign fy   = $signed({{(CW-15){side_r[14]}}, side_r});

  logic signed [CW-1:0] x0, y0, z0;
  assign x0 = (flip ? -fx : fx) <<< 16;
  assign y0 = (flip ? -fy : fy) <<< 16;
  assign z0 = $signed({{(CW-17){s1[16]}}, s1}) <<< 16;

  // ---------------- units
  unit_ctl_t cor_ctl, sq_ctl, div_ctl;
  unit_sts_t cor_sts, sq_sts, div_sts;
  logic signed [CW-1:0] cor_x, cor_y;
  logic [31:0] root;
  logic        rem_nz;
  logic [13:0] dq;
  logic [43:0] div_num;

  assign cor_ctl.start = (state_r == S_VERT) && en;
  assign sq_ctl.start  = (state_r == S_SQ) && (ph_r == 2'd3);

  ahvl_cordic #(.STEPS(CORDIC_STEPS)) u_cordic (
    .clk(clk), .rst_n(rst_n), .ctl(cor_ctl), .x0(x0), .y0(y0), .z0(z0),
    .sts(cor_sts), .x(cor_x), .y(cor_y)
  );

  ahvl_isqrt u_isqrt (
    .clk(clk), .rst_n(rst_n), .ctl(sq_ctl), .n(sum_r),
    .sts(sq_sts), .root(root), .rem_nz(rem_nz)
  );

  logic [31:0] lim;
  logic        limited;
  assign lim     = {3'b000, mgs_r, 16'd0};
  assign limited = (root > lim) || ((root == lim) && rem_nz);

  assign div_ctl.start = ((state_r == S_SQRT) && sq_sts.done && limited) ||
                         ((state_r == S_DIVX) && div_sts.done);
  assign div_num = (state_r == S_SQRT) ? dx_r : dy_r;

  ahvl_div u_div (
    .clk(clk), .rst_n(rst_n), .ctl(div_ctl), .num(div_num), .den(root),
    .sts(div_sts), .q(dq)
  );

  // ---------------- gain multiply, split in two 17-bit halves
  logic signed [CW-1:0] gsrc;
  logic signed [17:0]   gop;
  logic signed [48:0]   gprod;
  logic signed [65:0]   gext, gfull;

  assign gsrc  = ph_r[1] ? cy_r : cx_r;
  assign gop   = ph_r[0] ? $signed({gsrc[CW-1], gsrc[CW-1:17]}) : $signed({1'b0, gsrc[16:0]});
  assign gprod = gop * $signed({1'b0, GAIN_Q30});
  assign gext  = $signed({{17{gprod[48]}}, gprod});
  assign gfull = acc_r + (gext <<< 17);

  // ---------------- squares and scaled magnitudes
  logic [30:0] ax, ay, sa;
  logic [61:0] sqp;
  logic [43:0] mp;

  assign ax  = xq_r[31] ? 31'(-xq_r) : xq_r[30:0];
  assign ay  = yq_r[31] ? 31'(-yq_r) : yq_r[30:0];
  assign sa  = ph_r[0] ? ay : ax;
  assign sqp = sa * sa;
  assign mp  = sa * mgs_r;

  // rounding to mm for the unlimited path
  logic signed [32:0] xr, yr;
  assign xr = $signed({xq_r[31], xq_r}) + 33'sd32768;
  assign yr = $signed({yq_r[31], yq_r}) + 33'sd32768;

  logic signed [35:0] dq36;
  assign dq36 = $signed({22'd0, dq});

  // ---------------- control
  logic out_free;
  assign out_free  = !out_valid_r || out_tready;
  assign in_tready = (state_r == S_IDLE);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: if (in_tvalid) state_nxt = S_VERT;
      S_VERT: state_nxt = en ? S_CORD : S_FIN;
      S_CORD: if (cor_sts.done) state_nxt = S_GMUL;
      S_GMUL: if (ph_r == 2'd3) state_nxt = S_SQ;
      S_SQ:   if (ph_r == 2'd3) state_nxt = S_SQRT;
      S_SQRT: if (sq_sts.done) state_nxt = limited ? S_DIVX : S_FIN;
      S_DIVX: if (div_sts.done) state_nxt = S_DIVY;
      S_DIVY: if (div_sts.done) state_nxt = S_FIN;
      S_FIN:  if (out_free) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      air_r       <= 1'b0;
      out_valid_r <= 1'b0;
      ph_r        <= 2'd0;
      tgt_r       <= 15'd1000;
      gain_r      <= 12'd384;
      mcs_r       <= 13'd600;
      mgs_r       <= 13'd1000;
      mtr_r       <= 13'd1000;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) begin
        case (cfg_idx)
          CFG_TARGET:    tgt_r  <= cfg_wdata;
          CFG_GAIN:      gain_r <= cfg_wdata[11:0];
          CFG_MAX_CLIMB: mcs_r  <= cfg_wdata[12:0];
          CFG_MAX_GND:   mgs_r  <= cfg_wdata[12:0];
          CFG_MAX_TURN:  mtr_r  <= cfg_wdata[12:0];
          default: ;
        endcase
      end
      if (state_r == S_VERT) air_r <= air_new;
      if ((state_r == S_GMUL) || (state_r == S_SQ)) ph_r <= ph_r + 1'b1;
      else ph_r <= 2'd0;
      if ((state_r == S_FIN) && out_free) out_valid_r <= 1'b1;
      else if (out_tready) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      alt_r  <= $signed(in_tdata[15:0]);
      head_r <= in_tdata[31:16];
      fwd_r  <= $signed(in_tdata[46:32]);
      side_r <= $signed(in_tdata[61:47]);
      turn_r <= $signed(in_tdata[76:62]);
      seen_r <= in_tdata[77];
      age_r  <= in_tdata[93:78];
    end
    case (state_r)
      S_VERT: begin
        vz_r <= sat14(vz36, mcs_r);
        vr_r <= en ? sat14($signed({{21{turn_r[14]}}, turn_r}), mtr_r) : 14'd0;
        ve_r <= 14'd0;
        vn_r <= 14'd0;
      end
      S_CORD: begin
        if (cor_sts.done) begin
          cx_r <= cor_x;
          cy_r <= cor_y;
        end
      end
      S_GMUL: begin
        if (!ph_r[0]) acc_r <= gext + 66'sd536870912;
        else if (!ph_r[1]) xq_r <= gfull[61:30];
        else yq_r <= gfull[61:30];
      end
      S_SQ: begin
        case (ph_r)
          2'd0: sum_r <= {2'b00, sqp};
          2'd1: sum_r <= sum_r + {2'b00, sqp};
          2'd2: dx_r  <= mp;
          default: dy_r <= mp;
        endcase
      end
      S_SQRT: begin
        if (sq_sts.done && !limited) begin
          ve_r <= sat14($signed({{19{xr[32]}}, xr[32:16]}), 13'h1fff);
          vn_r <= sat14($signed({{19{yr[32]}}, yr[32:16]}), 13'h1fff);
        end
      end
      S_DIVX: if (div_sts.done) ve_r <= sat14(xq_r[31] ? -dq36 : dq36, 13'h1fff);
      S_DIVY: if (div_sts.done) vn_r <= sat14(yq_r[31] ? -dq36 : dq36, 13'h1fff);
      S_FIN:  if (out_free) out_data_r <= {7'd0, air_r, vr_r, vz_r, vn_r, ve_r};
      default: ;
    endcase
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  `AHVL_ASSERT_NXT(a_air_latched, air_r, air_r, "airborne flag dropped")
  `AHVL_ASSERT_IMP(a_grounded_zero, out_tvalid && !out_tdata[56],
    (out_tdata[13:0] == 14'd0) && (out_tdata[27:14] == 14'd0) && (out_tdata[55:42] == 14'd0),
    "horizontal output nonzero while grounded")
  `AHVL_ASSERT_IMP(a_out_range, out_tvalid,
    ($signed(out_tdata[13:0]) <= 14'sd8000) && ($signed(out_tdata[13:0]) >= -14'sd8000) &&
    ($signed(out_tdata[27:14]) <= 14'sd8000) && ($signed(out_tdata[27:14]) >= -14'sd8000),
    "velocity output out of range")

endmodule

`default_nettype wire
